[rtl/pei_pkg.sv]
// pendulum euler integrator package: widths, fixed-point constants, atan table,
// fsm state type and the command/status structs between controller and datapath
// no dependencies
`default_nettype none

package pei_pkg;

  // default module parameters
  localparam int unsigned DefCordicIterations = 24;
  localparam int unsigned DefIndexWidth       = 20;

  // port and register widths
  localparam int unsigned DataW      = 32;
  localparam int unsigned StepIndexW = 20;
  localparam int unsigned StepSizeW  = 16;
  localparam int unsigned GainW      = 24;
  localparam int unsigned StepLimitW = 20;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEP_SIZE        = 3'd0,
    CFG_GRAVITY_OVER_LEN = 3'd1,
    CFG_INITIAL_ANGLE    = 3'd2,
    CFG_INITIAL_VELOCITY = 3'd3,
    CFG_STEP_LIMIT       = 3'd4
  } pei_cfg_idx_t;

  // configuration reset values
  localparam logic [StepSizeW-1:0]    ResetStepSize    = 16'd655;
  localparam logic [GainW-1:0]        ResetGravity     = 24'd642908;
  localparam logic signed [DataW-1:0] ResetInitAngle   = 32'sd134217728;
  localparam logic signed [DataW-1:0] ResetInitVel     = 32'sd0;
  localparam logic [StepLimitW-1:0]   ResetStepLimit   = 20'd1000;

  // angle range reduction, Q3.28 with one guard bit
  localparam int unsigned RedW = 33;
  localparam logic signed [RedW-1:0] PiQ28     = 33'sd843314857;
  localparam logic signed [RedW-1:0] TwoPiQ28  = 33'sd1686629713;
  localparam logic signed [RedW-1:0] HalfPiQ28 = 33'sd421657428;

  // cordic datapath, Q1.30 with headroom
  localparam int unsigned CorW     = 34;
  localparam int unsigned AtanIdxW = 5;
  localparam int unsigned AtanW    = 30;
  localparam logic signed [CorW-1:0] CordicGainQ30 = 34'sd652032874;

  // multiply and rounding widths
  localparam int unsigned ProdGW       = 59;  // (g/L) * sin
  localparam int unsigned AccW         = 42;  // acceleration, Q3.28
  localparam int unsigned ProdVW       = 59;  // dt * accel
  localparam int unsigned ProdAW       = 49;  // dt * velocity
  localparam int unsigned VelSumW      = 45;
  localparam int unsigned AngSumW      = 35;
  localparam int unsigned SatInW       = 45;
  localparam int unsigned GRoundShift  = 18;
  localparam int unsigned DtRoundShift = 16;
  localparam int          GHalf        = 1 << (GRoundShift - 1);
  localparam int          DtHalf       = 1 << (DtRoundShift - 1);

  // truncated atan(2^-i), Q1.30
  function automatic logic [AtanW-1:0] atan_q30(input logic [AtanIdxW-1:0] idx);
    logic [AtanW-1:0] val;
    case (idx)
      5'd0:    val = 30'd843314856;
      5'd1:    val = 30'd497837829;
      5'd2:    val = 30'd263043836;
      5'd3:    val = 30'd133525158;
      5'd4:    val = 30'd67021686;
      5'd5:    val = 30'd33543515;
      5'd6:    val = 30'd16775850;
      5'd7:    val = 30'd8388437;
      5'd8:    val = 30'd4194282;
      5'd9:    val = 30'd2097149;
      5'd10:   val = 30'd1048575;
      5'd11:   val = 30'd524287;
      5'd12:   val = 30'd262143;
      5'd13:   val = 30'd131071;
      5'd14:   val = 30'd65535;
      5'd15:   val = 30'd32767;
      5'd16:   val = 30'd16383;
      5'd17:   val = 30'd8191;
      5'd18:   val = 30'd4095;
      5'd19:   val = 30'd2047;
      5'd20:   val = 30'd1023;
      5'd21:   val = 30'd511;
      5'd22:   val = 30'd255;
      5'd23:   val = 30'd127;
      5'd24:   val = 30'd63;
      5'd25:   val = 30'd31;
      5'd26:   val = 30'd15;
      5'd27:   val = 30'd8;
      5'd28:   val = 30'd4;
      5'd29:   val = 30'd2;
      5'd30:   val = 30'd1;
      default: val = 30'd0;
    endcase
    return val;
  endfunction

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_ROTATE,
    ST_MUL_G,
    ST_ROUND_G,
    ST_MUL_DT,
    ST_UPDATE
  } pei_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic emit;     // capture current state into the output register
    logic reduce;   // range-reduce angle, start cordic
    logic rotate;   // one cordic iteration
    logic mul_g;    // (g/L) * sin
    logic round_g;  // round to acceleration
    logic mul_dt;   // dt * accel and dt * velocity
    logic update;   // write back angle, velocity, index
  } pei_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic past_limit;
    logic rot_done;
  } pei_status_t;

endpackage

`default_nettype wire

[rtl/pendulum_euler_integrator_top.sv]
// pendulum euler integrator top: one explicit euler step per input transfer.
// a new item is taken only in idle, after the iterative cordic sine unit and the
// rest of the step are done; the check state registers the current state as the
// result, an untaken result holds the step until it leaves, items past the limit
// return to idle with no step and no result.
// synchronous active-low reset loads config and state reset values, no clear pass.
// depends on pei_pkg, pei_ctrl, pei_dp
`default_nettype none

module pendulum_euler_integrator_top import pei_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = DefCordicIterations,
  parameter int unsigned INDEX_WIDTH       = DefIndexWidth
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [CfgDataW-1:0]   cfg_data,
  // step requests
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_restart,
  // step results
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [StepIndexW-1:0]      out_step_index,
  output logic signed [DataW-1:0]    out_angle,
  output logic signed [DataW-1:0]    out_velocity
);

  pei_cmd_t    cmd;
  pei_status_t status;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  pei_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pei_dp #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
    .INDEX_WIDTH       (INDEX_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_restart     (in_restart),
    .cmd            (cmd),
    .status         (status),
    .out_step_index (out_step_index),
    .out_angle      (out_angle),
    .out_velocity   (out_velocity)
  );

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a step is in progress");

  // a result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result captured over an untaken result");

  // datapath commands are exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit, cmd.reduce, cmd.rotate, cmd.mul_g, cmd.round_g,
              cmd.mul_dt, cmd.update}))
    else $error("more than one datapath command active");

  // state is only advanced for an index within the limit
  a_update_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> !status.past_limit)
    else $error("state update past the step limit");

  // multiply follows the last cordic rotation
  a_mul_after_rot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_g |-> ($past(cmd.rotate) && $past(status.rot_done)))
    else $error("sine multiply without a finished cordic run");

endmodule

`default_nettype wire

[rtl/pei_ctrl.sv]
// pendulum euler integrator controller: step sequencer fsm and output valid flag
// depends on pei_pkg
`default_nettype none

module pei_ctrl import pei_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire pei_status_t status,
  output pei_cmd_t         cmd
);

  pei_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // output slot can take a new result
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.past_limit) state_nxt = ST_IDLE;
        else if (out_free)     state_nxt = ST_REDUCE;
      end
      ST_REDUCE:  state_nxt = ST_ROTATE;
      ST_ROTATE: begin
        if (status.rot_done) state_nxt = ST_MUL_G;
      end
      ST_MUL_G:   state_nxt = ST_ROUND_G;
      ST_ROUND_G: state_nxt = ST_MUL_DT;
      ST_MUL_DT:  state_nxt = ST_UPDATE;
      ST_UPDATE:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_CHECK:   cmd.emit    = !status.past_limit && out_free;
      ST_REDUCE:  cmd.reduce  = 1'b1;
      ST_ROTATE:  cmd.rotate  = 1'b1;
      ST_MUL_G:   cmd.mul_g   = 1'b1;
      ST_ROUND_G: cmd.round_g = 1'b1;
      ST_MUL_DT:  cmd.mul_dt  = 1'b1;
      ST_UPDATE:  cmd.update  = 1'b1;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // result valid: set on emit, cleared on output transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)      out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/pei_dp.sv]
// pendulum euler integrator datapath: config registers, pendulum state,
// range reduction, iterative cordic sine, multiplies, rounding and saturation
// depends on pei_pkg
`default_nettype none

module pei_dp import pei_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = DefCordicIterations,
  parameter int unsigned INDEX_WIDTH       = DefIndexWidth
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [CfgDataW-1:0]   cfg_data,
  input  wire logic                  in_restart,
  input  wire pei_cmd_t              cmd,
  output pei_status_t                status,
  output logic [StepIndexW-1:0]      out_step_index,
  output logic signed [DataW-1:0]    out_angle,
  output logic signed [DataW-1:0]    out_velocity
);

  localparam int unsigned IndexRegW = INDEX_WIDTH + 1;
  localparam int unsigned CmpW      = (IndexRegW > StepLimitW) ? IndexRegW : StepLimitW;
  localparam int unsigned IdxExtW   = IndexRegW + StepIndexW;
  localparam int unsigned IterW     = $clog2(CORDIC_ITERATIONS);

  // clamp to the signed 32-bit range
  function automatic logic signed [DataW-1:0] sat32(input logic signed [SatInW-1:0] v);
    logic signed [SatInW-1:0] max_v;
    logic signed [SatInW-1:0] min_v;
    logic signed [DataW-1:0]  res;
    max_v = SatInW'(32'sh7fff_ffff);
    min_v = SatInW'(32'sh8000_0000);
    if (v > max_v)      res = 32'sh7fff_ffff;
    else if (v < min_v) res = 32'sh8000_0000;
    else                res = v[DataW-1:0];
    return res;
  endfunction

  // configuration registers
  logic [StepSizeW-1:0]    step_size_r;
  logic [GainW-1:0]        gravity_r;
  logic signed [DataW-1:0] init_angle_r;
  logic signed [DataW-1:0] init_vel_r;
  logic [StepLimitW-1:0]   step_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r  <= ResetStepSize;
      gravity_r    <= ResetGravity;
      init_angle_r <= ResetInitAngle;
      init_vel_r   <= ResetInitVel;
      step_limit_r <= ResetStepLimit;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_SIZE:        step_size_r  <= cfg_data[StepSizeW-1:0];
        CFG_GRAVITY_OVER_LEN: gravity_r    <= cfg_data[GainW-1:0];
        CFG_INITIAL_ANGLE:    init_angle_r <= signed'(cfg_data);
        CFG_INITIAL_VELOCITY: init_vel_r   <= signed'(cfg_data);
        CFG_STEP_LIMIT:       step_limit_r <= cfg_data[StepLimitW-1:0];
        default: ;
      endcase
    end
  end

  // pendulum state
  logic signed [DataW-1:0] angle_r, angle_nxt;
  logic signed [DataW-1:0] vel_r, vel_nxt;
  logic [IndexRegW-1:0]    index_r, index_nxt;

  // cordic and arithmetic registers
  logic signed [CorW-1:0]   x_r, x_nxt;
  logic signed [CorW-1:0]   y_r, y_nxt;
  logic signed [CorW-1:0]   z_r, z_nxt;
  logic [IterW-1:0]         iter_r, iter_nxt;
  logic signed [ProdGW-1:0] gprod_r, gprod_nxt;
  logic signed [AccW-1:0]   accel_r, accel_nxt;
  logic signed [ProdVW-1:0] dvprod_r, dvprod_nxt;
  logic signed [ProdAW-1:0] daprod_r, daprod_nxt;

  // output registers
  logic [StepIndexW-1:0]   out_step_index_r, out_step_index_nxt;
  logic signed [DataW-1:0] out_angle_r;
  logic signed [DataW-1:0] out_velocity_r;

  // limit check: index past the cap or past the configured limit
  assign status.past_limit = index_r[INDEX_WIDTH] ||
                             (CmpW'(index_r) > CmpW'(step_limit_r));
  assign status.rot_done   = (iter_r == IterW'(CORDIC_ITERATIONS - 1));

  // reduce angle to [-pi, pi], fold into [-pi/2, pi/2], move to Q1.30
  logic signed [RedW-1:0] red_a, red_wrap, red_fold;
  logic signed [CorW-1:0] z_start;

  always_comb begin
    red_a = RedW'(angle_r);
    if (red_a > PiQ28)       red_wrap = red_a - TwoPiQ28;
    else if (red_a < -PiQ28) red_wrap = red_a + TwoPiQ28;
    else                     red_wrap = red_a;
    if (red_wrap > HalfPiQ28)       red_fold = PiQ28 - red_wrap;
    else if (red_wrap < -HalfPiQ28) red_fold = -PiQ28 - red_wrap;
    else                            red_fold = red_wrap;
    z_start = CorW'(red_fold) <<< 2;
  end

  // one cordic rotation step
  logic signed [CorW-1:0] x_sh, y_sh, atan_s;

  assign x_sh   = x_r >>> iter_r;
  assign y_sh   = y_r >>> iter_r;
  assign atan_s = signed'(CorW'(atan_q30(AtanIdxW'(iter_r))));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    iter_nxt = iter_r;
    if (cmd.reduce) begin
      x_nxt    = CordicGainQ30;
      y_nxt    = '0;
      z_nxt    = z_start;
      iter_nxt = '0;
    end else if (cmd.rotate) begin
      if (!z_r[CorW-1]) begin
        x_nxt = x_r - y_sh;
        y_nxt = y_r + x_sh;
        z_nxt = z_r - atan_s;
      end else begin
        x_nxt = x_r + y_sh;
        y_nxt = y_r - x_sh;
        z_nxt = z_r + atan_s;
      end
      iter_nxt = iter_r + IterW'(1);
    end
  end

  // multiplies and rounding
  logic signed [GainW:0]      gravity_s;
  logic signed [StepSizeW:0]  step_s;
  logic signed [ProdGW-1:0]   g_sum;
  logic signed [ProdVW-1:0]   dv_sum;
  logic signed [ProdAW-1:0]   da_sum;
  logic signed [VelSumW-1:0]  vel_sum;
  logic signed [AngSumW-1:0]  ang_sum;

  assign gravity_s  = signed'({1'b0, gravity_r});
  assign step_s     = signed'({1'b0, step_size_r});
  assign gprod_nxt  = ProdGW'(gravity_s) * ProdGW'(y_r);
  assign g_sum      = gprod_r + ProdGW'(GHalf);
  assign accel_nxt  = AccW'(g_sum >>> GRoundShift);
  assign dvprod_nxt = ProdVW'(step_s) * ProdVW'(accel_r);
  assign daprod_nxt = ProdAW'(step_s) * ProdAW'(vel_r);
  assign dv_sum     = dvprod_r + ProdVW'(DtHalf);
  assign da_sum     = daprod_r + ProdAW'(DtHalf);
  assign vel_sum    = VelSumW'(vel_r) - VelSumW'(dv_sum >>> DtRoundShift);
  assign ang_sum    = AngSumW'(angle_r) + AngSumW'(da_sum >>> DtRoundShift);

  // state update: restart reload, euler write-back
  always_comb begin
    angle_nxt = angle_r;
    vel_nxt   = vel_r;
    index_nxt = index_r;
    if (cmd.accept && in_restart) begin
      angle_nxt = init_angle_r;
      vel_nxt   = init_vel_r;
      index_nxt = '0;
    end else if (cmd.update) begin
      angle_nxt = sat32(SatInW'(ang_sum));
      vel_nxt   = sat32(SatInW'(vel_sum));
      index_nxt = index_r + IndexRegW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= ResetInitAngle;
      vel_r   <= ResetInitVel;
      index_r <= '0;
    end else begin
      angle_r <= angle_nxt;
      vel_r   <= vel_nxt;
      index_r <= index_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    iter_r <= iter_nxt;
    if (cmd.mul_g)   gprod_r  <= gprod_nxt;
    if (cmd.round_g) accel_r  <= accel_nxt;
    if (cmd.mul_dt) begin
      dvprod_r <= dvprod_nxt;
      daprod_r <= daprod_nxt;
    end
  end

  // result capture
  logic [IdxExtW-1:0] idx_ext;

  assign idx_ext            = IdxExtW'(index_r);
  assign out_step_index_nxt = idx_ext[StepIndexW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_step_index_r <= out_step_index_nxt;
      out_angle_r      <= angle_r;
      out_velocity_r   <= vel_r;
    end
  end

  assign out_step_index = out_step_index_r;
  assign out_angle      = out_angle_r;
  assign out_velocity   = out_velocity_r;

endmodule

`default_nettype wire
